// ----- sv/ffza_pkg.sv -----
package ffza_pkg;

  localparam int HEAP_BYTES_DEF   = 65536;
  localparam int HEADER_BYTES_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

  localparam logic [16:0] LIMIT_RESET = 17'h10000;
  localparam logic [16:0] USED_MAX    = 17'h1FFFF;

  localparam logic [7:0] HDR_STAT_FREE = 8'd0;
  localparam logic [7:0] HDR_STAT_USED = 8'd1;

  typedef enum logic [1:0] {
    ALLOC_OK      = 2'd0,
    ALLOC_ZERO    = 2'd1,
    ALLOC_NOINIT  = 2'd2,
    ALLOC_FULL    = 2'd3
  } alloc_status_t;

  // Packed so that status lands in the lowest bits.
  typedef struct packed {
    logic [16:0]   bytes_used;
    logic [15:0]   payload_addr;
    alloc_status_t status;
  } alloc_res_t;

endpackage

// ----- sv/ffza_heap_ram.sv -----
module ffza_heap_ram import ffza_pkg::*; #(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/ffza_out_reg.sv -----
module ffza_out_reg import ffza_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        res_valid,
  input  alloc_res_t  res,
  output logic        res_ready,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata
);

  alloc_res_t data_q;

  assign res_ready     = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = {5'b0, data_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_q <= res;
    end
  end

endmodule

// ----- sv/ffza_seq.sv -----
module ffza_seq import ffza_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [31:0]                   in_data,
  input  logic [15:0]                   heap_base,
  input  logic [16:0]                   heap_limit,
  input  logic                          base_wr,
  output logic                          res_valid,
  input  logic                          res_ready,
  output alloc_res_t                    res,
  output logic                          mem_we,
  output logic [$clog2(HEAP_BYTES)-1:0] mem_waddr,
  output logic [7:0]                    mem_wdata,
  output logic                          mem_re,
  output logic [$clog2(HEAP_BYTES)-1:0] mem_raddr,
  input  logic [7:0]                    mem_rdata
);

  localparam int AW       = $clog2(HEAP_BYTES);
  localparam int SZ_BYTES = (HEADER_BYTES - 1 > 3) ? 3 : HEADER_BYTES - 1;
  localparam int SZ_W     = 8 * SZ_BYTES;
  localparam int MAX_W    = (SZ_W > 17) ? ((SZ_W > AW) ? SZ_W : AW) : ((AW > 17) ? AW : 17);
  localparam int LOC_W    = MAX_W + 1;
  localparam int RC_W     = $clog2(SZ_BYTES + 2);

  localparam logic [LOC_W-1:0] HDR_LOC  = LOC_W'(HEADER_BYTES);
  localparam logic [AW-1:0]    HDR_ADDR = AW'(HEADER_BYTES);
  localparam logic [RC_W-1:0]  RD_LAST  = RC_W'(SZ_BYTES + 1);
  localparam logic [RC_W-1:0]  WR_FULL  = RC_W'(SZ_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WALK, S_READ, S_EVAL, S_PLACE, S_HDR, S_FILL, S_DONE
  } state_t;

  state_t             state;
  logic [15:0]        cnt_q;
  logic [15:0]        size_q;
  logic [31:0]        total;
  logic [LOC_W-1:0]   loc;
  logic [16:0]        bump;
  logic [16:0]        used;
  logic [7:0]         hstat;
  logic [SZ_W-1:0]    bsize;
  logic [RC_W-1:0]    rd_cnt;
  logic [AW-1:0]      wh_addr;
  logic [7:0]         wh_stat;
  logic [SZ_W-1:0]    wh_size;
  logic [RC_W-1:0]    wh_cnt;
  logic [RC_W-1:0]    wh_last;
  logic               main_pend;
  logic [AW-1:0]      fill_addr;
  logic [31:0]        fill_left;
  alloc_status_t      res_status;
  logic [15:0]        res_addr;

  logic [33:0]        place_sum;
  logic               place_full;
  logic               place_ok;
  logic [32:0]        used_sum;
  logic [16:0]        used_next;
  logic [31:0]        bsize_w;
  logic               fits;
  logic [31:0]        spare;
  logic               split;
  logic [LOC_W-1:0]   payload_loc;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = '{bytes_used: used, payload_addr: res_addr, status: res_status};

  assign place_sum  = 34'(bump) + 34'(total) + 34'(HEADER_BYTES);
  assign place_full = place_sum >= 34'(heap_limit);
  assign place_ok   = (state == S_PLACE) && !place_full;

  assign used_sum    = 33'(used) + 33'(total) + 33'(HEADER_BYTES);
  assign used_next   = (used_sum > 33'(USED_MAX)) ? USED_MAX : used_sum[16:0];
  assign bsize_w     = 32'(bsize);
  assign fits        = (hstat != HDR_STAT_USED) && (bsize_w >= total);
  assign spare       = bsize_w - total;
  assign split       = spare > 32'(HEADER_BYTES);
  assign payload_loc = loc + HDR_LOC;

  // Memory port: reads only while walking, writes only while building headers
  // or filling, so a read never meets a write to the same byte.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = loc[AW-1:0] + AW'(rd_cnt);
    mem_we    = 1'b0;
    mem_waddr = fill_addr;
    mem_wdata = 8'd0;
    if (state == S_READ && rd_cnt <= WR_FULL) begin
      mem_re = 1'b1;
    end
    if (state == S_HDR) begin
      mem_we    = 1'b1;
      mem_waddr = wh_addr + AW'(wh_cnt);
      if (wh_cnt == '0) begin
        mem_wdata = wh_stat;
      end
      for (int b = 0; b < SZ_BYTES; b++) begin
        if (wh_cnt == RC_W'(b + 1)) begin
          mem_wdata = wh_size[8*b +: 8];
        end
      end
    end else if (state == S_FILL) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bump      <= '0;
      used      <= '0;
      main_pend <= 1'b0;
    end else begin
      if (base_wr) begin
        bump <= 17'(heap_base);
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt_q  <= in_data[15:0];
            size_q <= in_data[31:16];
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          total    <= cnt_q * size_q;
          res_addr <= '0;
          loc      <= LOC_W'(heap_base);
          priority if (cnt_q == '0 || size_q == '0) begin
            res_status <= ALLOC_ZERO;
            state      <= S_DONE;
          end else if (heap_base == '0) begin
            res_status <= ALLOC_NOINIT;
            state      <= S_DONE;
          end else begin
            res_status <= ALLOC_OK;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          rd_cnt <= '0;
          state  <= (loc < LOC_W'(bump)) ? S_READ : S_PLACE;
        end
        S_READ: begin
          if (rd_cnt == RC_W'(1)) begin
            hstat <= mem_rdata;
          end
          for (int b = 0; b < SZ_BYTES; b++) begin
            if (rd_cnt == RC_W'(b + 2)) begin
              bsize[8*b +: 8] <= mem_rdata;
            end
          end
          if (rd_cnt == RD_LAST) begin
            state <= S_EVAL;
          end else begin
            rd_cnt <= rd_cnt + RC_W'(1);
          end
        end
        S_EVAL: begin
          priority if (bsize == '0) begin
            state <= S_PLACE;
          end else if (fits) begin
            used     <= used_next;
            res_addr <= payload_loc[15:0];
            wh_cnt   <= '0;
            state    <= S_HDR;
            if (split) begin
              wh_addr   <= loc[AW-1:0] + HDR_ADDR + total[AW-1:0];
              wh_stat   <= HDR_STAT_FREE;
              wh_size   <= SZ_W'(spare - 32'(HEADER_BYTES));
              wh_last   <= WR_FULL;
              main_pend <= 1'b1;
            end else begin
              wh_addr <= loc[AW-1:0];
              wh_stat <= HDR_STAT_USED;
              wh_size <= SZ_W'(total);
              wh_last <= '0;
            end
          end else begin
            loc   <= loc + LOC_W'(bsize) + HDR_LOC;
            state <= S_WALK;
          end
        end
        S_PLACE: begin
          if (place_full) begin
            res_status <= ALLOC_FULL;
            state      <= S_DONE;
          end else begin
            bump     <= place_sum[16:0];
            used     <= used_next;
            res_addr <= payload_loc[15:0];
            wh_addr  <= loc[AW-1:0];
            wh_stat  <= HDR_STAT_USED;
            wh_size  <= SZ_W'(total);
            wh_last  <= WR_FULL;
            wh_cnt   <= '0;
            state    <= S_HDR;
          end
        end
        S_HDR: begin
          if (wh_cnt == wh_last) begin
            wh_cnt <= '0;
            if (main_pend) begin
              // split tail is down, now mark the taken block
              main_pend <= 1'b0;
              wh_addr   <= loc[AW-1:0];
              wh_stat   <= HDR_STAT_USED;
              wh_size   <= SZ_W'(total);
              wh_last   <= WR_FULL;
            end else begin
              fill_addr <= loc[AW-1:0] + HDR_ADDR;
              fill_left <= total;
              state     <= S_FILL;
            end
          end else begin
            wh_cnt <= wh_cnt + RC_W'(1);
          end
        end
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          fill_left <= fill_left - 32'd1;
          if (fill_left == 32'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("heap read and write in the same cycle");

  a_bump_source: assert property (@(posedge clk) disable iff (rst)
    !$stable(bump) |-> $past(base_wr) || $past(place_ok))
    else $error("bump pointer moved without base write or placement");

  a_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> (fill_left != 32'd0))
    else $error("zero fill running with nothing left");

  a_used_monotonic: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (used >= $past(used)))
    else $error("used byte count decreased");

  a_ok_has_addr: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != ALLOC_OK) |-> (res_addr == '0))
    else $error("failed request carries a payload address");

endmodule

// ----- sv/first_fit_zeroing_allocator.sv -----
// First-fit allocator over a byte heap with in-band block headers.
//
// Channels: s_axis carries one request (elem_count, elem_size); m_axis returns
// one item per request (status, payload_addr, bytes_used). cfg writes heap_base
// (index 0, also loads the bump pointer) and heap_limit (index 1); cfg_ready is
// always high, other indexes are dropped. Write configuration only while no
// request is in flight.
//
// Flow: one request at a time, taken only in the idle state. A rejected
// request (zero size or no heap) goes from the multiply step straight to the
// output register; any other walks H headers, each with S = min(HEADER_BYTES-1,
// 3) size bytes, writes W header bytes (1, S+1 or 2S+2) and zero-fills N payload
// bytes: the walk reads and the fill clears one heap RAM byte per cycle. The
// sequencer returns to idle, ready for the next request, as a result enters the
// output register. HEAP_BYTES is a power of 2.
//
// Reset (rst, synchronous) clears base, bump pointer and used count, sets the
// limit to 65536 and leaves the heap RAM as is. While m_axis_tready is low a
// result waits in the output register; the next request runs to its own result,
// then holds and stalls s_axis until the register frees.
module first_fit_zeroing_allocator import ffza_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // elem_count[15:0], elem_size[31:16]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // status[1:0], payload_addr[17:2],
                                                // bytes_used[34:18], zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(HEAP_BYTES);

  logic [15:0]   heap_base;
  logic [16:0]   heap_limit;
  logic          base_wr;
  logic          res_valid;
  logic          res_ready;
  alloc_res_t    res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  assign cfg_ready = 1'b1;

  // Hold the configuration registers. Pulse base_wr the cycle after a base
  // write, so the sequencer reloads bump from the new heap_base.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_limit <= LIMIT_RESET;
      base_wr    <= 1'b0;
    end else begin
      base_wr <= cfg_valid && (cfg_index == CFG_HEAP_BASE);
      if (cfg_valid) begin
        if (cfg_index == CFG_HEAP_BASE) begin
          heap_base <= cfg_data[15:0];
        end else if (cfg_index == CFG_HEAP_LIMIT) begin
          heap_limit <= cfg_data;
        end
      end
    end
  end

  ffza_seq #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .heap_base  (heap_base),
    .heap_limit (heap_limit),
    .base_wr    (base_wr),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ffza_heap_ram #(
    .AW (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffza_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
